FILE: design/tpac_pkg.sv
// ----------------------------------------------------------------------------
// tpac_pkg: shared types and constants of the two-point angle calibrator
// Widths of the calibration arithmetic, scale constants and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tpac_pkg;

  localparam int unsigned RawW    = 12;  // raw sample and calibration points
  localparam int unsigned AngleW  = 14;  // calibrated angle, centidegrees
  localparam int unsigned ProdW   = 25;  // |delta| * 4500 fits in 25 bits
  localparam int unsigned CntW    = 5;   // divider step counter

  localparam int unsigned DivSteps = ProdW;  // one quotient bit per step

  localparam logic [12:0]       ScaleAt45 = 13'd4500;
  localparam logic [AngleW-1:0] FullScale = 14'd9000;
  localparam logic [AngleW:0]   Deadband  = 15'd20;

  // Configuration register indexes.
  localparam logic CfgZeroPoint = 1'b0;
  localparam logic CfgPointAt45 = 1'b1;

  // Status that the divider returns to the sequencer.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ProdW-1:0] quotient;
  } tpac_div_stat_t;

endpackage

`default_nettype wire

FILE: design/tpac_div.sv
// ----------------------------------------------------------------------------
// tpac_div: iterative restoring divider
// Unsigned 25-by-12-bit division, one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tpac_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [tpac_pkg::ProdW-1:0]  dividend_i,
  input  wire logic [tpac_pkg::RawW-1:0]   divisor_i,
  output tpac_pkg::tpac_div_stat_t         stat_o
);
  import tpac_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ProdW-1:0]  dvd_q, dvd_d;
  logic [RawW-1:0]   rem_q, rem_d;
  logic [RawW-1:0]   dvs_q, dvs_d;
  logic [RawW:0]     rem_sh;
  logic [RawW-1:0]   rem_sub;
  logic              qbit;

  // The remainder stays below the divisor, so the shifted value fits 13 bits.
  // When the divisor fits, the difference is below the divisor again, so the
  // low 12 bits of the subtraction carry the whole new remainder.
  assign rem_sh  = {rem_q, dvd_q[ProdW-1]};
  assign rem_sub = rem_sh[RawW-1:0] - dvs_q;
  assign qbit    = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = qbit ? rem_sub : rem_sh[RawW-1:0];
      dvd_d = {dvd_q[ProdW-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy     = busy_q;
  assign stat_o.done     = done_q;
  assign stat_o.quotient = dvd_q;

endmodule

`default_nettype wire

FILE: design/two_point_angle_calibrator_top.sv
// ----------------------------------------------------------------------------
// two_point_angle_calibrator_top: two-point angle calibration with deadband
// Maps a raw 12-bit angle sample to centidegrees and holds it with hysteresis.
// ----------------------------------------------------------------------------
// Usage:
// Raw samples enter on the s_axis stream; one transfer carries one sample in
// tdata[11:0]. Every sample yields exactly one result transfer on m_axis:
// the held angle in centidegrees (0..9000) and a flag that tells whether this
// sample moved the held angle by more than 20 centidegrees.
// The calibration points are written through the cfg port (index 0: zero point, index
// 1: 45-degree point); the user must do so only while idle, as the block does not check.
// Processing: the sign-magnitude product is formed in the accept cycle and then
// the restoring divider produces one quotient bit per cycle. When the divider is
// done, the clamped value is registered; the deadband check follows as the result
// is written into the output register. s_axis_tready is low while the sequencer
// is busy, so the block takes a new sample only once the last one has been handed
// to the output register.
// Stalls: the output register holds a finished result until it is taken, and
// a new sample is accepted meanwhile. A further result waits in the sequencer
// until the output register frees up.
// Reset: the held angle clears to 0, the zero point to 0 and the 45-degree
// point to 512; no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module two_point_angle_calibrator_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Sample input stream.
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [15:0]                s_axis_tdata,   // [11:0] raw_angle
  // Result output stream.
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [15:0]                     m_axis_tdata,   // [13:0] angle_centideg,
                                                          // [14] changed
  // Configuration write port.
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_addr_i,
  input  wire logic [tpac_pkg::RawW-1:0]  cfg_wdata_i
);
  import tpac_pkg::*;

  // Sequencer states.
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StPush = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [RawW-1:0]    zero_point_q;
  logic [RawW-1:0]    point_at_45_q;
  logic [AngleW-1:0]  held_q, held_d;
  logic               neg_q, neg_d;
  logic [AngleW-1:0]  value_q, value_d;
  logic               m_valid_q, m_valid_d;
  logic [AngleW-1:0]  m_angle_q, m_angle_d;
  logic               m_changed_q, m_changed_d;

  logic               in_xfer;
  logic [RawW-1:0]    raw;
  logic [RawW:0]      delta;
  logic [RawW:0]      span;
  logic [RawW-1:0]    delta_mag;
  logic [RawW-1:0]    span_mag;
  logic [ProdW-1:0]   product;
  logic               out_free;
  logic [AngleW:0]    diff;
  logic [AngleW:0]    diff_mag;
  logic               over_band;

  tpac_div_stat_t     div_stat;

  assign raw     = s_axis_tdata[RawW-1:0];
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Signed differences in 13 bits; the division works on magnitudes and the
  // sign afterwards only decides whether the result clamps to zero.
  assign delta     = {1'b0, raw} - {1'b0, zero_point_q};
  assign span      = {1'b0, point_at_45_q} - {1'b0, zero_point_q};
  assign delta_mag = delta[RawW] ? RawW'(-delta) : delta[RawW-1:0];
  // A zero span counts as a span of one.
  assign span_mag  = (span == '0) ? RawW'(1) :
                     (span[RawW] ? RawW'(-span) : span[RawW-1:0]);
  assign product   = ProdW'(delta_mag * ScaleAt45);

  tpac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer),
    .dividend_i (product),
    .divisor_i  (span_mag),
    .stat_o     (div_stat)
  );

  // Deadband check against the held angle.
  assign diff      = {1'b0, value_q} - {1'b0, held_q};
  assign diff_mag  = diff[AngleW] ? -diff : diff;
  assign over_band = (diff_mag > Deadband);

  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    value_d     = value_q;
    held_d      = held_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_angle_d   = m_angle_q;
    m_changed_d = m_changed_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          // A negative quotient always clamps to zero.
          neg_d   = delta[RawW] ^ (span[RawW] && (span != '0));
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_stat.done) begin
          if (neg_q) begin
            value_d = '0;
          end else if (div_stat.quotient > ProdW'(FullScale)) begin
            value_d = FullScale;
          end else begin
            value_d = div_stat.quotient[AngleW-1:0];
          end
          state_d = StPush;
        end
      end
      StPush: begin
        if (out_free) begin
          if (over_band) begin
            held_d = value_q;
          end
          m_valid_d   = 1'b1;
          m_angle_d   = over_band ? value_q : held_q;
          m_changed_d = over_band;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      zero_point_q  <= '0;
      point_at_45_q <= RawW'(512);
      held_q        <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CfgZeroPoint: zero_point_q  <= cfg_wdata_i;
          CfgPointAt45: point_at_45_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q       <= neg_d;
    value_q     <= value_d;
    m_angle_q   <= m_angle_d;
    m_changed_q <= m_changed_d;
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_changed_q, m_angle_q};

endmodule

`default_nettype wire
